[rtl/i2cbb_pkg.sv]
// Shared types and constants of the bit-banged I2C master.
`default_nettype none
package i2cbb_pkg;

	localparam int unsigned KindW      = 3;
	localparam int unsigned ByteW      = 8;
	localparam int unsigned CfgW       = 16;
	localparam int unsigned DelayBitsD = 16;
	localparam int unsigned InDataW    = 16;
	localparam int unsigned OutDataW   = 16;

	// command codes carried on the input tuser
	localparam logic [KindW-1:0] KIND_NONE  = 3'd0;
	localparam logic [KindW-1:0] KIND_START = 3'd1;
	localparam logic [KindW-1:0] KIND_STOP  = 3'd2;
	localparam logic [KindW-1:0] KIND_WRITE = 3'd3;
	localparam logic [KindW-1:0] KIND_READ  = 3'd4;

	// one result beat, after the tick's update
	typedef struct packed {
		logic             ack_seen;
		logic [ByteW-1:0] rx_byte;
		logic             done_res;
		logic             busy_res;
		logic             sda_pull_low;
		logic             scl_pull_low;
	} i2cbb_res_t;

endpackage : i2cbb_pkg
`default_nettype wire

[rtl/i2cbb_engine.sv]
// Bus sequencer: holds the command state and works out one tick per step enable.
`default_nettype none
module i2cbb_engine #(
	parameter int unsigned DELAY_BITS = i2cbb_pkg::DelayBitsD
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic [i2cbb_pkg::KindW-1:0]  kind,
	input  wire logic [i2cbb_pkg::ByteW-1:0]  tx_byte,
	input  wire logic                         send_ack,
	input  wire logic                         scl_level,
	input  wire logic                         sda_level,
	input  wire logic [DELAY_BITS-1:0]        phase_delay,
	output i2cbb_pkg::i2cbb_res_t             res
);
	import i2cbb_pkg::*;

	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] ST_SDA_REL  = 5'd1;
	localparam logic [4:0] ST_SCL_REL  = 5'd2;
	localparam logic [4:0] ST_POLL     = 5'd3;
	localparam logic [4:0] ST_PAUSE    = 5'd4;
	localparam logic [4:0] ST_SDA_LOW  = 5'd5;
	localparam logic [4:0] ST_PAUSE2   = 5'd6;
	localparam logic [4:0] ST_SCL_LOW  = 5'd7;
	localparam logic [4:0] SP_SDA_LOW  = 5'd8;
	localparam logic [4:0] SP_SCL_REL  = 5'd9;
	localparam logic [4:0] SP_POLL     = 5'd10;
	localparam logic [4:0] SP_PAUSE    = 5'd11;
	localparam logic [4:0] SP_SDA_REL  = 5'd12;
	localparam logic [4:0] WR_SDA_BIT  = 5'd13;
	localparam logic [4:0] WR_SCL_REL  = 5'd14;
	localparam logic [4:0] WR_POLL     = 5'd15;
	localparam logic [4:0] WR_SCL_LOW  = 5'd16;
	localparam logic [4:0] WR_PAUSE    = 5'd17;
	localparam logic [4:0] WR_SDA_REL  = 5'd18;
	localparam logic [4:0] WR_SCL_REL2 = 5'd19;
	localparam logic [4:0] WR_POLL2    = 5'd20;
	localparam logic [4:0] WR_SCL_LOW2 = 5'd21;
	localparam logic [4:0] RD_SDA_REL  = 5'd22;
	localparam logic [4:0] RD_SCL_REL  = 5'd23;
	localparam logic [4:0] RD_POLL     = 5'd24;
	localparam logic [4:0] RD_SCL_LOW  = 5'd25;
	localparam logic [4:0] RD_ACK      = 5'd26;
	localparam logic [4:0] RD_SCL_REL2 = 5'd27;
	localparam logic [4:0] RD_POLL2    = 5'd28;
	localparam logic [4:0] RD_PAUSE    = 5'd29;
	localparam logic [4:0] RD_SCL_LOW2 = 5'd30;
	localparam logic [4:0] RD_SDA_REL2 = 5'd31;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	logic [4:0]            phase_q,   phase_d;
	logic [KindW-1:0]      cmd_q,     cmd_d;
	logic [3:0]            bitcnt_q,  bitcnt_d;
	logic [ByteW-1:0]      shift_q,   shift_d;
	logic [DELAY_BITS-1:0] wait_q,    wait_d;
	logic                  ackwant_q, ackwant_d;
	logic                  scl_q,     scl_d;
	logic                  sda_q,     sda_d;
	logic                  ackflag_q, ackflag_d;
	logic [ByteW-1:0]      rdres_q,   rdres_d;
	logic                  done;
	logic                  kind_ok;
	logic [3:0]            bit_inc;

	assign kind_ok = (kind == KIND_START) || (kind == KIND_STOP) ||
	                 (kind == KIND_WRITE) || (kind == KIND_READ);
	assign bit_inc = bitcnt_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		bitcnt_d  = bitcnt_q;
		shift_d   = shift_q;
		wait_d    = wait_q;
		ackwant_d = ackwant_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		ackflag_d = ackflag_q;
		rdres_d   = rdres_q;
		done      = 1'b0;
		if (wait_q != '0) begin
			wait_d = wait_q - DELAY_BITS'(1);
		end else begin
			// every step that changes a line or pauses reloads the wait
			unique case (phase_q)
				PH_IDLE: begin
					if (cmd_q != KIND_NONE) begin
						done  = 1'b1;
						cmd_d = KIND_NONE;
					end else if (kind_ok) begin
						cmd_d     = kind;
						bitcnt_d  = '0;
						ackwant_d = send_ack;
						shift_d   = (kind == KIND_WRITE) ? tx_byte : '0;
						unique case (kind)
							KIND_START: phase_d = ST_SDA_REL;
							KIND_STOP:  phase_d = SP_SDA_LOW;
							KIND_WRITE: phase_d = WR_SDA_BIT;
							default:    phase_d = RD_SDA_REL;
						endcase
					end
				end
				ST_SDA_REL:  begin sda_d = 1'b0; wait_d = phase_delay; phase_d = ST_SCL_REL; end
				ST_SCL_REL:  begin scl_d = 1'b0; wait_d = phase_delay; phase_d = ST_POLL; end
				ST_POLL:     if (scl_level) phase_d = ST_PAUSE;
				ST_PAUSE:    begin wait_d = phase_delay; phase_d = ST_SDA_LOW; end
				ST_SDA_LOW:  begin sda_d = 1'b1; wait_d = phase_delay; phase_d = ST_PAUSE2; end
				ST_PAUSE2:   begin wait_d = phase_delay; phase_d = ST_SCL_LOW; end
				ST_SCL_LOW:  begin scl_d = 1'b1; wait_d = phase_delay; phase_d = PH_IDLE; end
				SP_SDA_LOW:  begin sda_d = 1'b1; wait_d = phase_delay; phase_d = SP_SCL_REL; end
				SP_SCL_REL:  begin scl_d = 1'b0; wait_d = phase_delay; phase_d = SP_POLL; end
				SP_POLL:     if (scl_level) phase_d = SP_PAUSE;
				SP_PAUSE:    begin wait_d = phase_delay; phase_d = SP_SDA_REL; end
				SP_SDA_REL:  begin sda_d = 1'b0; wait_d = phase_delay; phase_d = PH_IDLE; end
				WR_SDA_BIT: begin
					sda_d   = ~shift_q[ByteW-1];
					wait_d  = phase_delay;
					phase_d = WR_SCL_REL;
				end
				WR_SCL_REL:  begin scl_d = 1'b0; wait_d = phase_delay; phase_d = WR_POLL; end
				WR_POLL:     if (scl_level) phase_d = WR_SCL_LOW;
				WR_SCL_LOW: begin
					scl_d    = 1'b1;
					shift_d  = {shift_q[ByteW-2:0], 1'b0};
					bitcnt_d = bit_inc;
					wait_d   = phase_delay;
					phase_d  = (bit_inc < BITS_PER_BYTE) ? WR_SDA_BIT : WR_PAUSE;
				end
				WR_PAUSE:    begin wait_d = phase_delay; phase_d = WR_SDA_REL; end
				WR_SDA_REL:  begin sda_d = 1'b0; wait_d = phase_delay; phase_d = WR_SCL_REL2; end
				WR_SCL_REL2: begin scl_d = 1'b0; wait_d = phase_delay; phase_d = WR_POLL2; end
				WR_POLL2: begin
					if (scl_level) begin
						ackflag_d = ~sda_level;
						phase_d   = WR_SCL_LOW2;
					end
				end
				WR_SCL_LOW2: begin scl_d = 1'b1; wait_d = phase_delay; phase_d = PH_IDLE; end
				RD_SDA_REL:  begin sda_d = 1'b0; wait_d = phase_delay; phase_d = RD_SCL_REL; end
				RD_SCL_REL:  begin scl_d = 1'b0; wait_d = phase_delay; phase_d = RD_POLL; end
				RD_POLL: begin
					if (scl_level) begin
						shift_d = {shift_q[ByteW-2:0], sda_level};
						phase_d = RD_SCL_LOW;
					end
				end
				RD_SCL_LOW: begin
					scl_d    = 1'b1;
					bitcnt_d = bit_inc;
					wait_d   = phase_delay;
					phase_d  = (bit_inc < BITS_PER_BYTE) ? RD_SCL_REL : RD_ACK;
				end
				RD_ACK: begin
					rdres_d = shift_q;
					sda_d   = ackwant_q;
					wait_d  = phase_delay;
					phase_d = RD_SCL_REL2;
				end
				RD_SCL_REL2: begin scl_d = 1'b0; wait_d = phase_delay; phase_d = RD_POLL2; end
				RD_POLL2:    if (scl_level) phase_d = RD_PAUSE;
				RD_PAUSE:    begin wait_d = phase_delay; phase_d = RD_SCL_LOW2; end
				RD_SCL_LOW2: begin scl_d = 1'b1; wait_d = phase_delay; phase_d = RD_SDA_REL2; end
				RD_SDA_REL2: begin sda_d = 1'b0; wait_d = phase_delay; phase_d = PH_IDLE; end
				default:     phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cmd_q     <= KIND_NONE;
			bitcnt_q  <= '0;
			shift_q   <= '0;
			wait_q    <= '0;
			ackwant_q <= 1'b0;
			scl_q     <= 1'b0;
			sda_q     <= 1'b0;
			ackflag_q <= 1'b0;
			rdres_q   <= '0;
		end else if (adv) begin
			phase_q   <= phase_d;
			cmd_q     <= cmd_d;
			bitcnt_q  <= bitcnt_d;
			shift_q   <= shift_d;
			wait_q    <= wait_d;
			ackwant_q <= ackwant_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			ackflag_q <= ackflag_d;
			rdres_q   <= rdres_d;
		end
	end

	// result seen after this tick's update
	always_comb begin
		res.scl_pull_low = scl_d;
		res.sda_pull_low = sda_d;
		res.busy_res     = (cmd_d != KIND_NONE);
		res.done_res     = done;
		res.rx_byte      = rdres_d;
		res.ack_seen     = ackflag_d;
	end

endmodule : i2cbb_engine
`default_nettype wire

[rtl/i2c_bitbang_master.sv]
// Top level of the bit-banged I2C master: stream ports, delay register, result register.
// Each accepted tick beat gives its result beat from a register, in the next cycle.
// Throughput: one tick beat per cycle; the result register frees s_tready whenever
// m_tready is high, so ticks stream back to back.
// Reset (arst_n low, asynchronous): idle, both lines released, delay 0, no result held.
`default_nettype none
module i2c_bitbang_master #(
	parameter int unsigned DELAY_BITS = i2cbb_pkg::DelayBitsD
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// tick beats in
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// [7:0] tx_byte, [8] send_ack, [9] scl_level, [10] sda_level, rest zero
	input  wire logic [i2cbb_pkg::InDataW-1:0]   s_tdata,
	// [2:0] kind
	input  wire logic [i2cbb_pkg::KindW-1:0]     s_tuser,
	// result beats out
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
	// [11:4] rx_byte, [12] ack_seen, rest zero
	output      logic [i2cbb_pkg::OutDataW-1:0]  m_tdata,
	// phase_delay register
	input  wire logic                            cfg_we,
	input  wire logic [i2cbb_pkg::CfgW-1:0]      cfg_wdata
);
	import i2cbb_pkg::*;

	localparam int unsigned ResW = $bits(i2cbb_res_t);

	logic                  s_acc;
	logic [DELAY_BITS-1:0] delay_q;
	i2cbb_res_t            res_d;
	i2cbb_res_t            res_q;
	logic                  m_valid_q;

	// a tick is taken whenever the result slot is empty or being drained
	assign s_tready = ~m_valid_q | m_tready;
	assign s_acc    = s_tvalid & s_tready;

	// delay is kept at DELAY_BITS: upper bits of the write dropped, or zero-filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
		end else if (cfg_we) begin
			delay_q <= DELAY_BITS'(cfg_wdata);
		end
	end

	i2cbb_engine #(
		.DELAY_BITS (DELAY_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (s_acc),
		.kind        (s_tuser),
		.tx_byte     (s_tdata[ByteW-1:0]),
		.send_ack    (s_tdata[ByteW]),
		.scl_level   (s_tdata[ByteW+1]),
		.sda_level   (s_tdata[ByteW+2]),
		.phase_delay (delay_q),
		.res         (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// payload register, loaded with each accepted tick
	always_ff @(posedge clk) begin
		if (s_acc) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OutDataW-ResW){1'b0}}, res_q};

	// done and busy never show in the same result
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(res_q.done_res && res_q.busy_res))
		else $error("done and busy together");

	// an accepted tick always leaves a result behind
	a_acc_gives_res: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_valid_q)
		else $error("accepted tick without result");

	// a draining consumer never stalls the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// a taken tick that raises done never shows busy with it
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && res_d.done_res) |-> !res_d.busy_res)
		else $error("done raised while command still held");

endmodule : i2c_bitbang_master
`default_nettype wire

[tb/i2c_tick_checker.sv]
`timescale 1ns / 1ps
// Checker for the bit-banged I2C master: predicts every result beat and compares it field by field.
module i2c_tick_checker #(
	parameter int unsigned DELAY_BITS = i2cbb_pkg::DelayBitsD
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [i2cbb_pkg::InDataW-1:0]  s_tdata,
	input  wire logic [i2cbb_pkg::KindW-1:0]    s_tuser,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [i2cbb_pkg::OutDataW-1:0] m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [i2cbb_pkg::CfgW-1:0]     cfg_wdata,
	output      int                             errors,
	output      int                             outstanding,
	output      logic                           quiet
);
	import i2cbb_pkg::*;

	localparam int BitsPerByte = 8;
	localparam logic [31:0] DelayMask32 =
		(DELAY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << DELAY_BITS) - 32'd1);

	typedef enum logic [4:0] {
		IDLE,
		STA_SDA_UP, STA_SCL_UP, STA_WAIT_SCL, STA_HOLD, STA_SDA_DN, STA_HOLD2, STA_SCL_DN,
		STO_SDA_DN, STO_SCL_UP, STO_WAIT_SCL, STO_HOLD, STO_SDA_UP,
		WR_BIT, WR_SCL_UP, WR_WAIT_SCL, WR_SCL_DN, WR_HOLD, WR_SDA_UP,
		WR_ACK_SCL_UP, WR_ACK_WAIT, WR_ACK_SCL_DN,
		RD_SDA_UP, RD_SCL_UP, RD_WAIT_SCL, RD_SCL_DN, RD_ACK_DRIVE,
		RD_ACK_SCL_UP, RD_ACK_WAIT, RD_ACK_HOLD, RD_ACK_SCL_DN, RD_SDA_FREE
	} bus_phase_t;

	// predicted controller state
	bus_phase_t         bus_phase;
	logic [KindW-1:0]   cur_cmd;
	logic [3:0]         bit_no;
	logic [ByteW-1:0]   shifter;
	logic [CfgW-1:0]    hold_cnt;
	logic [CfgW-1:0]    delay_set;
	logic               ack_req_q;
	logic               scl_drv;
	logic               sda_drv;
	logic               ack_got;
	logic [ByteW-1:0]   rx_last;

	i2cbb_res_t result_due[$];
	int fails = 0;

	assign errors = fails;

	task automatic hold_then(input bus_phase_t nxt);
		hold_cnt = delay_set;
		bus_phase = nxt;
	endtask

	// one tick of the controller; result taken after the update
	task automatic bus_tick(input logic [KindW-1:0] cmd, input logic [ByteW-1:0] txb,
			input logic ack_in, input logic scl_hi, input logic sda_hi,
			output i2cbb_res_t r);
		logic fin;
		fin = 1'b0;
		if (hold_cnt != '0) begin
			hold_cnt = hold_cnt - 1'b1;
		end else begin
			case (bus_phase)
			IDLE: begin
				if (cur_cmd != KIND_NONE) begin
					fin = 1'b1;
					cur_cmd = KIND_NONE;
				end else if (cmd >= KIND_START && cmd <= KIND_READ) begin
					cur_cmd = cmd;
					bit_no = '0;
					ack_req_q = ack_in;
					shifter = (cmd == KIND_WRITE) ? txb : '0;
					case (cmd)
					KIND_START: bus_phase = STA_SDA_UP;
					KIND_STOP:  bus_phase = STO_SDA_DN;
					KIND_WRITE: bus_phase = WR_BIT;
					default:    bus_phase = RD_SDA_UP;
					endcase
				end
			end
			STA_SDA_UP:   begin sda_drv = 1'b0; hold_then(STA_SCL_UP); end
			STA_SCL_UP:   begin scl_drv = 1'b0; hold_then(STA_WAIT_SCL); end
			STA_WAIT_SCL: if (scl_hi) bus_phase = STA_HOLD;
			STA_HOLD:     hold_then(STA_SDA_DN);
			STA_SDA_DN:   begin sda_drv = 1'b1; hold_then(STA_HOLD2); end
			STA_HOLD2:    hold_then(STA_SCL_DN);
			STA_SCL_DN:   begin scl_drv = 1'b1; hold_then(IDLE); end
			STO_SDA_DN:   begin sda_drv = 1'b1; hold_then(STO_SCL_UP); end
			STO_SCL_UP:   begin scl_drv = 1'b0; hold_then(STO_WAIT_SCL); end
			STO_WAIT_SCL: if (scl_hi) bus_phase = STO_HOLD;
			STO_HOLD:     hold_then(STO_SDA_UP);
			STO_SDA_UP:   begin sda_drv = 1'b0; hold_then(IDLE); end
			WR_BIT:       begin sda_drv = ~shifter[ByteW-1]; hold_then(WR_SCL_UP); end
			WR_SCL_UP:    begin scl_drv = 1'b0; hold_then(WR_WAIT_SCL); end
			WR_WAIT_SCL:  if (scl_hi) bus_phase = WR_SCL_DN;
			WR_SCL_DN: begin
				scl_drv = 1'b1;
				shifter = shifter << 1;
				bit_no = bit_no + 1'b1;
				if (bit_no < BitsPerByte) hold_then(WR_BIT);
				else hold_then(WR_HOLD);
			end
			WR_HOLD:       hold_then(WR_SDA_UP);
			WR_SDA_UP:     begin sda_drv = 1'b0; hold_then(WR_ACK_SCL_UP); end
			WR_ACK_SCL_UP: begin scl_drv = 1'b0; hold_then(WR_ACK_WAIT); end
			WR_ACK_WAIT: begin
				if (scl_hi) begin
					ack_got = ~sda_hi;
					bus_phase = WR_ACK_SCL_DN;
				end
			end
			WR_ACK_SCL_DN: begin scl_drv = 1'b1; hold_then(IDLE); end
			RD_SDA_UP:     begin sda_drv = 1'b0; hold_then(RD_SCL_UP); end
			RD_SCL_UP:     begin scl_drv = 1'b0; hold_then(RD_WAIT_SCL); end
			RD_WAIT_SCL: begin
				if (scl_hi) begin
					shifter = {shifter[ByteW-2:0], sda_hi};
					bus_phase = RD_SCL_DN;
				end
			end
			RD_SCL_DN: begin
				scl_drv = 1'b1;
				bit_no = bit_no + 1'b1;
				if (bit_no < BitsPerByte) hold_then(RD_SCL_UP);
				else hold_then(RD_ACK_DRIVE);
			end
			RD_ACK_DRIVE: begin
				rx_last = shifter;
				sda_drv = ack_req_q;
				hold_then(RD_ACK_SCL_UP);
			end
			RD_ACK_SCL_UP: begin scl_drv = 1'b0; hold_then(RD_ACK_WAIT); end
			RD_ACK_WAIT:   if (scl_hi) bus_phase = RD_ACK_HOLD;
			RD_ACK_HOLD:   hold_then(RD_ACK_SCL_DN);
			RD_ACK_SCL_DN: begin scl_drv = 1'b1; hold_then(RD_SDA_FREE); end
			RD_SDA_FREE:   begin sda_drv = 1'b0; hold_then(IDLE); end
			default:       bus_phase = IDLE;
			endcase
		end
		r.scl_pull_low = scl_drv;
		r.sda_pull_low = sda_drv;
		r.busy_res     = (cur_cmd != KIND_NONE);
		r.done_res     = fin;
		r.rx_byte      = rx_last;
		r.ack_seen     = ack_got;
	endtask

	task automatic note_mismatch(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		fails++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		i2cbb_res_t r;
		i2cbb_res_t want;
		i2cbb_res_t got;
		if (!arst_n) begin
			bus_phase = IDLE;
			cur_cmd   = KIND_NONE;
			bit_no    = '0;
			shifter   = '0;
			hold_cnt  = '0;
			delay_set = '0;
			ack_req_q = 1'b0;
			scl_drv   = 1'b0;
			sda_drv   = 1'b0;
			ack_got   = 1'b0;
			rx_last   = '0;
			result_due.delete();
			outstanding <= 0;
			quiet <= 1'b1;
		end else begin
			if (s_tvalid && s_tready) begin
				bus_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], s_tdata[10], r);
				result_due.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (result_due.size() == 0) begin
					fails++;
					$display("%0t: result beat with nothing expected, expected none, actual %0h",
						$time, m_tdata);
				end else begin
					want = result_due.pop_front();
					got = i2cbb_res_t'(m_tdata[12:0]);
					if (m_tdata[15:13] != '0)
						note_mismatch("padding", 16'(0), 16'(m_tdata[15:13]));
					if (got.scl_pull_low !== want.scl_pull_low)
						note_mismatch("scl_pull_low", 16'(want.scl_pull_low),
							16'(got.scl_pull_low));
					if (got.sda_pull_low !== want.sda_pull_low)
						note_mismatch("sda_pull_low", 16'(want.sda_pull_low),
							16'(got.sda_pull_low));
					if (got.busy_res !== want.busy_res)
						note_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res));
					if (got.done_res !== want.done_res)
						note_mismatch("done_res", 16'(want.done_res), 16'(got.done_res));
					if (got.rx_byte !== want.rx_byte)
						note_mismatch("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
					if (got.ack_seen !== want.ack_seen)
						note_mismatch("ack_seen", 16'(want.ack_seen), 16'(got.ack_seen));
				end
			end
			if (cfg_we)
				delay_set = cfg_wdata & DelayMask32[CfgW-1:0];
			outstanding <= result_due.size();
			quiet <= (bus_phase == IDLE && cur_cmd == KIND_NONE && hold_cnt == '0);
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the I2C master testbench: clock, reset, tick stimulus, receiver stalls and verdict.
module testbench;
	import i2cbb_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int SegTicks      = 100;
	localparam int NumSegs       = 8;
	// how the fake bus answers on SDA during a directed command
	localparam int SdaLow  = 0;
	localparam int SdaHigh = 1;
	localparam int SdaAny  = 2;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	wire                 s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic [KindW-1:0]    s_tuser = KIND_NONE;
	wire                 m_tvalid;
	logic                m_tready = 1'b0;
	wire [OutDataW-1:0]  m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgW-1:0]     cfg_wdata = '0;

	int   src_idle_pct = 8;
	int   dst_idle_pct = 85;
	int   stall_cycles = 0;
	int   stretch_left = 0;
	int   errors;
	int   outstanding;
	logic quiet;

	// delay per random segment: mostly tiny so commands stay short
	int unsigned delay_plan [NumSegs] = '{0, 1, 3, 2, 0, 7, 1, 0};

	i2c_bitbang_master DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	i2c_tick_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (outstanding),
		.quiet       (quiet)
	);

	always #5 clk = ~clk;

	// receiver: stalls at random, rate set per phase of the run
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
	end

	// watchdog: any accepted beat on either side resets it
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WatchdogLimit) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// SCL as the bus would show it: mostly high, with the odd stretch held low
	function automatic logic next_scl();
		if (stretch_left > 0) begin
			stretch_left--;
			return 1'b0;
		end
		if ($urandom_range(0, 99) < 3) begin
			stretch_left = $urandom_range(3, 30);
			return 1'b0;
		end
		return ($urandom_range(0, 9) != 0);
	endfunction

	function automatic logic pick_sda(input int mode);
		if (mode == SdaLow)
			return 1'b0;
		if (mode == SdaHigh)
			return 1'b1;
		return 1'($urandom);
	endfunction

	// one tick beat; optional sender gap first, valid left high on return
	task automatic put_tick(input logic [KindW-1:0] cmd, input logic [ByteW-1:0] txb,
			input logic ack_req, input logic scl_hi, input logic sda_hi);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'b0, sda_hi, scl_hi, ack_req, txb};
		do @(posedge clk); while (!s_tready);
	endtask

	// idle ticks until the predicted controller is back in idle; quiet is registered,
	// and the loop always sends at least one idle tick
	task automatic settle_bus();
		do put_tick(KIND_NONE, 8'($urandom), 1'($urandom), 1'b1, 1'($urandom));
		while (!quiet);
	endtask

	// sender holds off until every expected result beat is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	task automatic set_delay(input logic [CfgW-1:0] value);
		settle_bus();
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// a command followed by ticks until it has finished; noisy ticks carry random
	// kinds, which a busy controller must ignore
	task automatic run_command(input logic [KindW-1:0] cmd, input logic [ByteW-1:0] txb,
			input logic ack_req, input int sda_mode, input bit noisy, input int stretch);
		stretch_left = stretch;
		put_tick(cmd, txb, ack_req, 1'b1, pick_sda(sda_mode));
		do put_tick(noisy ? 3'($urandom_range(0, 7)) : KIND_NONE, 8'($urandom),
				1'($urandom), next_scl(), pick_sda(sda_mode));
		while (!quiet);
		settle_bus();
	endtask

	initial begin
		int seg;
		int k;
		logic [KindW-1:0] kind_pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, sender light and receiver heavy ---
		// no-op and unused kinds while idle
		for (k = 0; k < (1 << KindW); k++) begin
			if (k == 0 || k > int'(KIND_READ))
				put_tick(3'(k), 8'($urandom), 1'($urandom), 1'b1, 1'($urandom));
		end
		set_delay('0);
		run_command(KIND_START, 8'h00, 1'b0, SdaAny,  1'b0, 0);
		run_command(KIND_WRITE, 8'hFF, 1'b0, SdaLow,  1'b0, 0);  // slave ACKs
		run_command(KIND_WRITE, 8'h00, 1'b1, SdaHigh, 1'b1, 0);  // NACK, busy noise
		run_command(KIND_WRITE, 8'hA5, 1'b0, SdaAny,  1'b0, 0);
		run_command(KIND_READ,  8'h00, 1'b1, SdaHigh, 1'b0, 0);  // all ones, ACK out
		run_command(KIND_READ,  8'hFF, 1'b0, SdaLow,  1'b0, 0);  // all zeros, NACK out
		run_command(KIND_READ,  8'h5A, 1'b1, SdaAny,  1'b1, 0);
		run_command(KIND_STOP,  8'h00, 1'b0, SdaAny,  1'b0, 0);
		// slave holds SCL low for a long while during the start
		run_command(KIND_START, 8'h00, 1'b0, SdaAny,  1'b0, 40);
		set_delay(16'd1);
		run_command(KIND_START, 8'h00, 1'b0, SdaAny,  1'b0, 0);
		run_command(KIND_WRITE, 8'h81, 1'b0, SdaLow,  1'b1, 12);
		run_command(KIND_READ,  8'h00, 1'b1, SdaAny,  1'b0, 0);
		run_command(KIND_STOP,  8'h00, 1'b0, SdaAny,  1'b0, 0);
		// longer delay on one short command
		set_delay(16'h0020);
		run_command(KIND_STOP,  8'h00, 1'b0, SdaAny,  1'b0, 0);

		// --- random: sender light/receiver heavy, then reversed, then flat out ---
		for (seg = 0; seg < NumSegs; seg++) begin
			if (seg < 3) begin
				src_idle_pct = 8;
				dst_idle_pct = 85;
			end else if (seg < 6) begin
				src_idle_pct = 85;
				dst_idle_pct = 8;
			end else begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			set_delay(16'(delay_plan[seg]));
			repeat (SegTicks) begin
				kind_pick = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : KIND_NONE;
				put_tick(kind_pick, 8'($urandom), 1'($urandom), next_scl(), 1'($urandom));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
